// ===== rtl/tsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants of the touch swipe detector.
// ----------------------------------------------------------------------------
package tsd_pkg;

    localparam int unsigned FIELD_BITS  = 12;
    localparam int unsigned THRESH_BITS = 12;
    localparam int unsigned DIR_BITS    = 2;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd1023;

    typedef enum logic [1:0] {
        REQ_X     = 2'd0,
        REQ_Y     = 2'd1,
        REQ_LEVEL = 2'd2,
        REQ_TAKE  = 2'd3
    } req_type_t;

    typedef enum logic [DIR_BITS-1:0] {
        DIR_NONE  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } dir_t;

    typedef struct packed {
        req_type_t              req_type;
        logic [FIELD_BITS-1:0]  event_value;
    } req_t;

    typedef struct packed {
        dir_t                   nav_dir;
        logic                   live_pressed;
        logic [FIELD_BITS-1:0]  live_y;
        logic [FIELD_BITS-1:0]  live_x;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/touch_swipe_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_swipe_detector
// Tracks touch events and reports left and right swipes on release.
// ----------------------------------------------------------------------------
// Accepts one event item per clock while the result side is not stalled and
// returns one result item for each: an item passes the input register, then
// the state update feeding the result register. Back-pressure on m_tready
// stalls both registers together, so s_tready depends combinationally on
// m_tready. The swipe threshold is written through cfg_we / cfg_wdata; the user
// writes it only while no item is in flight, and the block does not enforce this.
// ----------------------------------------------------------------------------
module touch_swipe_detector #(
    parameter int unsigned COORD_BITS = 12
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [11:0] event_value, [15:12] zero
    input  wire  [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [11:0] live_x, [23:12] live_y,
                                   // [24] live_pressed, [26:25] nav_dir, [31:27] zero
    input  wire         cfg_we,
    input  wire  [11:0] cfg_wdata
);

    logic [tsd_pkg::THRESH_BITS-1:0] thresh_reg;
    logic                            in_valid_reg;
    tsd_pkg::req_t                   in_req_reg;
    logic                            out_valid_reg;
    tsd_pkg::result_t                out_res_reg;
    tsd_pkg::result_t                result;
    logic                            advance;
    logic                            fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= tsd_pkg::THRESH_RESET;
        end else if (cfg_we) begin
            thresh_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg.req_type    <= tsd_pkg::req_type_t'(s_tuser);
            in_req_reg.event_value <= s_tdata[tsd_pkg::FIELD_BITS-1:0];
        end
    end

    tsd_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .req       (in_req_reg),
        .threshold (thresh_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_res_reg};

endmodule
`default_nettype wire

// ===== rtl/tsd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_core
// Touch state: live point, press origin, tracking and pending direction,
// with the release-edge swipe decision.
// ----------------------------------------------------------------------------
module tsd_core #(
    parameter int unsigned COORD_BITS = 12
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               fire,
    input  wire tsd_pkg::req_t                req,
    input  wire [tsd_pkg::THRESH_BITS-1:0]    threshold,
    output tsd_pkg::result_t                  result
);

    localparam int unsigned CMP_BITS =
        (COORD_BITS > tsd_pkg::THRESH_BITS) ? COORD_BITS : tsd_pkg::THRESH_BITS;

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0] origin_x_reg, origin_x_next;
    logic [COORD_BITS-1:0] origin_y_reg, origin_y_next;
    logic                  pressed_reg, pressed_next;
    logic                  tracking_reg, tracking_next;
    tsd_pkg::dir_t         pending_reg, pending_next;
    tsd_pkg::dir_t         dir_out;

    logic [COORD_BITS-1:0] val_c;
    logic                  touched;
    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic                  swipe;

    assign val_c   = COORD_BITS'(req.event_value);
    assign touched = |req.event_value;

    assign dx  = {1'b0, cur_x_reg} - {1'b0, origin_x_reg};
    assign dy  = {1'b0, cur_y_reg} - {1'b0, origin_y_reg};
    assign adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    assign swipe = (CMP_BITS'(adx) > CMP_BITS'(threshold)) && (adx > ady);

    always_comb begin
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        pressed_next  = pressed_reg;
        tracking_next = tracking_reg;
        pending_next  = pending_reg;
        dir_out       = pending_reg;
        case (req.req_type)
            tsd_pkg::REQ_X: begin
                cur_x_next = val_c;
            end
            tsd_pkg::REQ_Y: begin
                cur_y_next = val_c;
            end
            tsd_pkg::REQ_LEVEL: begin
                if (touched && !pressed_reg) begin
                    origin_x_next = cur_x_reg;
                    origin_y_next = cur_y_reg;
                    tracking_next = 1'b1;
                end else if (!touched && pressed_reg && tracking_reg) begin
                    if (swipe) begin
                        pending_next = dx[COORD_BITS] ? tsd_pkg::DIR_LEFT
                                                      : tsd_pkg::DIR_RIGHT;
                    end
                    tracking_next = 1'b0;
                end
                pressed_next = touched;
                dir_out      = pending_next;
            end
            tsd_pkg::REQ_TAKE: begin
                pending_next = tsd_pkg::DIR_NONE;
            end
            default: begin
                pending_next = pending_reg;
            end
        endcase
    end

    always_comb begin
        result.live_x       = tsd_pkg::FIELD_BITS'(cur_x_next);
        result.live_y       = tsd_pkg::FIELD_BITS'(cur_y_next);
        result.live_pressed = pressed_next;
        result.nav_dir      = dir_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            pressed_reg  <= 1'b0;
            tracking_reg <= 1'b0;
            pending_reg  <= tsd_pkg::DIR_NONE;
        end else if (fire) begin
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            pressed_reg  <= pressed_next;
            tracking_reg <= tracking_next;
            pending_reg  <= pending_next;
        end
    end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the touch swipe detector. A short table of hand
// picked events (extreme coordinates, repeated touch levels, left and right
// swipes, threshold and diagonal ties) is followed by random press, move and
// release gestures mixed with stray events, under several swipe thresholds.
// Each item is predicted on acceptance and every result is compared field
// by field, in order, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module testbench;

    import tsd_pkg::*;

    localparam int RESULT_BITS     = $bits(result_t);
    localparam int DIRECTED_ROWS   = 27;
    localparam int PHASES          = 7;
    localparam int PHASE_ITEMS     = 135;
    localparam int WATCHDOG_CYCLES = 2000;

    typedef struct packed {
        req_type_t             kind;
        logic [FIELD_BITS-1:0] value;
        logic                  fixed;
        result_t               want;
    } touch_item_t;

    typedef enum logic [1:0] {
        RX_READY,
        RX_RANDOM,
        RX_PATTERN,
        RX_HOLD
    } rx_mode_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    wire         s_tready;
    logic [15:0] s_tdata   = '0;   // [11:0] event_value, [15:12] zero
    logic [1:0]  s_tuser   = '0;   // [1:0] req_type
    wire         m_tvalid;
    logic        m_tready  = 1'b0;
    wire  [31:0] m_tdata;          // [11:0] live_x, [23:12] live_y,
                                   // [24] live_pressed, [26:25] nav_dir
    logic        cfg_we    = 1'b0;
    logic [11:0] cfg_wdata = '0;

    touch_swipe_detector u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // tracker state as seen from outside
    logic [FIELD_BITS-1:0]  pt_x       = '0;
    logic [FIELD_BITS-1:0]  pt_y       = '0;
    logic                   pt_pressed = 1'b0;
    logic [FIELD_BITS-1:0]  org_x      = '0;
    logic [FIELD_BITS-1:0]  org_y      = '0;
    logic                   tracking   = 1'b0;
    dir_t                   pend_dir   = DIR_NONE;
    logic [THRESH_BITS-1:0] swipe_limit = THRESH_RESET;

    touch_item_t pending_items[$];
    result_t     expected_nav[$];
    int          queued;
    int          mismatches  = 0;
    int          idle_cycles = 0;
    int          burst_left  = 1;
    int          gap_left    = 0;
    int          stall_left  = 0;
    rx_mode_t    stall_mode  = RX_READY;
    logic [31:0] stall_bits  = '0;

    touch_item_t directed_rows [DIRECTED_ROWS] = '{
        '{REQ_TAKE,  12'h000, 1'b1, '{DIR_NONE, 1'b0, 12'h000, 12'h000}},
        '{REQ_X,     12'hFFF, 1'b1, '{DIR_NONE, 1'b0, 12'h000, 12'hFFF}},
        '{REQ_Y,     12'hFFF, 1'b1, '{DIR_NONE, 1'b0, 12'hFFF, 12'hFFF}},
        '{REQ_TAKE,  12'hFFF, 1'b1, '{DIR_NONE, 1'b0, 12'hFFF, 12'hFFF}},
        '{REQ_X,     12'h000, 1'b1, '{DIR_NONE, 1'b0, 12'hFFF, 12'h000}},
        '{REQ_Y,     12'h000, 1'b1, '{DIR_NONE, 1'b0, 12'h000, 12'h000}},
        '{REQ_LEVEL, 12'h000, 1'b1, '{DIR_NONE, 1'b0, 12'h000, 12'h000}},
        // left swipe of 1100
        '{REQ_X,     12'h7D0, 1'b0, '0},
        '{REQ_Y,     12'h1F4, 1'b0, '0},
        '{REQ_LEVEL, 12'h001, 1'b0, '0},
        '{REQ_LEVEL, 12'hFFF, 1'b0, '0},
        '{REQ_X,     12'h384, 1'b0, '0},
        '{REQ_LEVEL, 12'h000, 1'b0, '0},
        // right swipe overwriting the pending left one
        '{REQ_LEVEL, 12'h800, 1'b0, '0},
        '{REQ_X,     12'hFFF, 1'b0, '0},
        '{REQ_Y,     12'h000, 1'b0, '0},
        '{REQ_LEVEL, 12'h000, 1'b0, '0},
        '{REQ_TAKE,  12'h000, 1'b0, '0},
        // travel equal to the threshold
        '{REQ_X,     12'h3E8, 1'b0, '0},
        '{REQ_LEVEL, 12'h001, 1'b0, '0},
        '{REQ_X,     12'h7E7, 1'b0, '0},
        '{REQ_LEVEL, 12'h000, 1'b0, '0},
        // diagonal, |dx| equal to |dy|
        '{REQ_LEVEL, 12'h001, 1'b0, '0},
        '{REQ_X,     12'h000, 1'b0, '0},
        '{REQ_Y,     12'h7E7, 1'b0, '0},
        '{REQ_LEVEL, 12'h000, 1'b0, '0},
        '{REQ_TAKE,  12'h5A5, 1'b0, '0}
    };

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic result_t track_touch(input req_type_t kind,
                                            input logic [FIELD_BITS-1:0] value);
        result_t r;
        int      dx;
        int      dy;
        int      adx;
        int      ady;
        r.nav_dir = pend_dir;
        case (kind)
            REQ_X: pt_x = value;
            REQ_Y: pt_y = value;
            REQ_LEVEL: begin
                if (value != 0 && !pt_pressed) begin
                    org_x    = pt_x;
                    org_y    = pt_y;
                    tracking = 1'b1;
                end else if (value == 0 && pt_pressed && tracking) begin
                    dx  = int'(pt_x) - int'(org_x);
                    dy  = int'(pt_y) - int'(org_y);
                    adx = (dx < 0) ? -dx : dx;
                    ady = (dy < 0) ? -dy : dy;
                    if (adx > int'(swipe_limit) && adx > ady)
                        pend_dir = (dx < 0) ? DIR_LEFT : DIR_RIGHT;
                    tracking = 1'b0;
                end
                pt_pressed = (value != 0);
                r.nav_dir  = pend_dir;
            end
            default: pend_dir = DIR_NONE;
        endcase
        r.live_x       = pt_x;
        r.live_y       = pt_y;
        r.live_pressed = pt_pressed;
        return r;
    endfunction

    function automatic logic [FIELD_BITS-1:0] place_coord(input int base, input int off);
        int pos;
        pos = ($urandom_range(0, 1) != 0) ? base + off : base - off;
        if (pos > 4095) pos = base - off;
        if (pos < 0) pos = base + off;
        if (pos > 4095) pos = 4095;
        return pos[FIELD_BITS-1:0];
    endfunction

    task automatic push_item(input req_type_t kind, input logic [FIELD_BITS-1:0] value);
        pending_items.push_back('{kind, value, 1'b0, '0});
        queued++;
    endtask

    task automatic add_gesture(input int thr);
        int ox;
        int oy;
        int mag;
        int dmag;
        ox = $urandom_range(0, 4095);
        oy = $urandom_range(0, 4095);
        if ($urandom_range(0, 3) == 0)
            push_item(REQ_LEVEL, 12'h000);
        push_item(REQ_X, FIELD_BITS'(ox));
        push_item(REQ_Y, FIELD_BITS'(oy));
        push_item(REQ_LEVEL, FIELD_BITS'($urandom_range(1, 4095)));
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 2))
                0:       push_item(REQ_X, FIELD_BITS'($urandom_range(0, 4095)));
                1:       push_item(REQ_Y, FIELD_BITS'($urandom_range(0, 4095)));
                default: push_item(REQ_LEVEL, FIELD_BITS'($urandom_range(1, 4095)));
            endcase
        end
        case ($urandom_range(0, 3))
            0:       mag = thr;
            1:       mag = thr + 1;
            2:       mag = (thr > 0) ? thr - 1 : 0;
            default: mag = $urandom_range(0, 4095);
        endcase
        case ($urandom_range(0, 3))
            0:       dmag = mag;
            1:       dmag = (mag > 0) ? mag - 1 : 0;
            2:       dmag = 0;
            default: dmag = $urandom_range(0, 4095);
        endcase
        push_item(REQ_X, place_coord(ox, mag));
        push_item(REQ_Y, place_coord(oy, dmag));
        push_item(REQ_LEVEL, 12'h000);
        if ($urandom_range(0, 4) < 3)
            push_item(REQ_TAKE, FIELD_BITS'($urandom_range(0, 4095)));
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_nav.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // input side: bursts of items with random gaps between them
    always @(posedge aclk) begin : drive_items
        touch_item_t row;
        result_t     predicted;
        if (aresetn && (!s_tvalid || s_tready)) begin
            if (s_tvalid) begin
                row       = pending_items.pop_front();
                predicted = track_touch(row.kind, row.value);
                expected_nav.push_back(row.fixed ? row.want : predicted);
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                row = pending_items[0];
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0000, row.value};
                s_tuser  <= row.kind;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output side: ready in segments of free flow, random, pattern and hold
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = rx_mode_t'($urandom_range(0, 3));
            stall_left = (stall_mode == RX_HOLD) ? $urandom_range(1, 16)
                                                 : $urandom_range(8, 64);
            stall_bits = $urandom;
        end
        stall_left--;
        case (stall_mode)
            RX_READY:   m_tready <= 1'b1;
            RX_RANDOM:  m_tready <= ($urandom_range(0, 1) != 0);
            RX_PATTERN: m_tready <= stall_bits[stall_left % 32];
            default:    m_tready <= 1'b0;
        endcase
    end

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RESULT_BITS-1:0]);
            if (expected_nav.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: tdata %h", m_tdata);
            end else begin
                want = expected_nav.pop_front();
                if (got.live_x !== want.live_x || got.live_y !== want.live_y ||
                    got.live_pressed !== want.live_pressed ||
                    got.nav_dir !== want.nav_dir) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x %0d y %0d pressed %0b dir %0d, %s %0d %0d %0b %0d",
                                 want.live_x, want.live_y, want.live_pressed, want.nav_dir,
                                 "got", got.live_x, got.live_y, got.live_pressed,
                                 got.nav_dir);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : run_phases
        int p;
        int thr;
        int pick;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i])
            pending_items.push_back(directed_rows[i]);
        wait_drained();
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0:       thr = 0;
                1:       thr = 4095;
                2:       thr = 1;
                3:       thr = 2048;
                4:       thr = $urandom_range(0, 4095);
                5:       thr = $urandom_range(0, 255);
                default: thr = int'(THRESH_RESET);
            endcase
            @(posedge aclk);
            cfg_we      <= 1'b1;
            cfg_wdata   <= THRESH_BITS'(thr);
            swipe_limit = THRESH_BITS'(thr);
            @(posedge aclk);
            cfg_we <= 1'b0;
            queued = 0;
            while (queued < PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    add_gesture(thr);
                end else if (pick < 9) begin
                    repeat ($urandom_range(1, 5))
                        push_item(req_type_t'($urandom_range(0, 3)),
                                  ($urandom_range(0, 3) == 0)
                                      ? 12'hFFF
                                      : FIELD_BITS'($urandom_range(0, 4095)));
                end else begin
                    push_item(REQ_TAKE, FIELD_BITS'($urandom_range(0, 4095)));
                end
            end
            wait_drained();
        end
        if (mismatches == 0 && expected_nav.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
